>>> src/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned OccWidth     = 4;
  localparam int unsigned DefaultDepth = 8;

  typedef enum logic [1:0] {
    ActPushBack  = 2'd0,
    ActPushFront = 2'd1,
    ActPopBack   = 2'd2,
    ActPopFront  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef logic signed [DataWidth-1:0] word_t;

endpackage

>>> src/deq_if.sv
interface deq_req_if;
  import deq_pkg::*;

  logic    valid;
  logic    ready;
  action_e action;
  word_t   push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic                 valid;
  logic                 ready;
  status_e              status;
  word_t                pop_value;
  logic [OccWidth-1:0]  occupancy;

  modport source (output valid, output status, output pop_value, output occupancy, input ready);
  modport sink (input valid, input status, input pop_value, input occupancy, output ready);
endinterface

>>> src/deq_ram.sv
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/double_ended_queue.sv
// Bounded double-ended queue of DEPTH signed 32-bit words held as a ring in a
// single-port RAM, with front and back pointers and an element count. Each
// request (push back, push front, pop back, pop front) gives exactly one
// response carrying a status (ok, full, empty), the popped word (zero unless
// a pop succeeds) and the occupancy after the step, truncated to 4 bits.
// A push, or any refused request, loads the response register directly; a
// successful pop first reads the registered-output RAM in the read state. A
// new request is taken only in the idle state, while the response register is
// empty or being drained in the same cycle.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  localparam int unsigned AddrWidth  = $clog2(DEPTH);
  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  state_e                 state_q, state_d;
  logic [AddrWidth-1:0]   front_q, front_d;
  logic [AddrWidth-1:0]   back_q, back_d;
  logic [CountWidth-1:0]  cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  word_t                  out_pop_q, out_pop_d;
  logic [OccWidth-1:0]    out_occ_q, out_occ_d;

  logic                   ram_en, ram_we;
  logic [AddrWidth-1:0]   ram_addr;
  logic [DataWidth-1:0]   ram_rdata;
  logic                   accept, full, empty;
  logic [CountWidth+OccWidth-1:0] occ_ext;

  function automatic logic [AddrWidth-1:0] ptr_next(logic [AddrWidth-1:0] p);
    return (p == AddrWidth'(DEPTH - 1)) ? '0 : p + AddrWidth'(1);
  endfunction

  function automatic logic [AddrWidth-1:0] ptr_prev(logic [AddrWidth-1:0] p);
    return (p == '0) ? AddrWidth'(DEPTH - 1) : p - AddrWidth'(1);
  endfunction

  assign req_i.ready = (state_q == StIdle) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (cnt_q == CountWidth'(DEPTH));
  assign empty       = (cnt_q == '0);
  assign occ_ext     = {{OccWidth{1'b0}}, cnt_d};

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    back_d       = back_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_pop_d    = out_pop_q;
    out_occ_d    = out_occ_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = front_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_status_d = StatOk;
          out_pop_d    = '0;
          unique case (req_i.action)
            ActPushBack: begin
              if (full) begin
                out_status_d = StatFull;
              end else begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = back_q;
                back_d   = ptr_next(back_q);
                cnt_d    = cnt_q + CountWidth'(1);
              end
              out_valid_d = 1'b1;
            end
            ActPushFront: begin
              if (full) begin
                out_status_d = StatFull;
              end else begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = ptr_prev(front_q);
                front_d  = ptr_prev(front_q);
                cnt_d    = cnt_q + CountWidth'(1);
              end
              out_valid_d = 1'b1;
            end
            ActPopBack: begin
              if (empty) begin
                out_status_d = StatEmpty;
                out_valid_d  = 1'b1;
              end else begin
                ram_en   = 1'b1;
                ram_addr = ptr_prev(back_q);
                back_d   = ptr_prev(back_q);
                cnt_d    = cnt_q - CountWidth'(1);
                state_d  = StRead;
              end
            end
            ActPopFront: begin
              if (empty) begin
                out_status_d = StatEmpty;
                out_valid_d  = 1'b1;
              end else begin
                ram_en   = 1'b1;
                ram_addr = front_q;
                front_d  = ptr_next(front_q);
                cnt_d    = cnt_q - CountWidth'(1);
                state_d  = StRead;
              end
            end
            default: ;
          endcase
          out_occ_d = occ_ext[OccWidth-1:0];
        end
      end
      StRead: begin
        out_valid_d  = 1'b1;
        out_status_d = StatOk;
        out_pop_d    = word_t'(ram_rdata);
        out_occ_d    = occ_ext[OccWidth-1:0];
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      front_q      <= '0;
      back_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StatOk;
      out_pop_q    <= '0;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      back_q       <= back_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_pop_q    <= out_pop_d;
      out_occ_q    <= out_occ_d;
    end
  end

  deq_ram #(
    .WIDTH (DataWidth),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req_i.push_value),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.pop_value = out_pop_q;
  assign rsp_o.occupancy = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountWidth'(DEPTH))
    else $error("element count exceeds depth");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRead |-> !out_valid_q && !req_i.ready)
    else $error("response register busy during read");

  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !empty && (req_i.action == ActPopBack || req_i.action == ActPopFront)
    |=> state_q == StRead && cnt_q == $past(cnt_q) - CountWidth'(1))
    else $error("successful pop did not start a read");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != StatOk |-> out_pop_q == '0)
    else $error("refused request carries a popped word");

endmodule
